FILE: hw/rtl/lzwlc_pkg.sv
// Shared types and constants of the LZW letter compressor.
// Used by every module of the block; depends on nothing else.
package lzwlc_pkg;

    localparam int LET_W         = 5;
    localparam int CODE_W        = 12;
    localparam int PAIR_W        = CODE_W + LET_W;
    localparam int ALPHABET      = 26;
    localparam int FIRST_LEARNED = 27;
    localparam int DICT_SIZE_DEF = 4096;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 16;

    // Search token that walks the row of dictionary cells.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [PAIR_W-1:0] key;
        logic [CODE_W-1:0] hit;
    } tok_t;

    // One result beat.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PUSH
    } state_t;

endpackage

FILE: hw/rtl/lzw_letter_compressor.sv
// Top level of the LZW letter compressor: control sequencer, dictionary row and result buffer.
// Depends on lzwlc_pkg, lzwlc_chain and lzwlc_out_buf.
//
// Usage:
// The input stream carries one letter per beat (s_tdata[4:0], 0 = A to 25 = Z) with
// s_tlast marking the final letter of a message. Letters 26 to 31 are dropped with
// their s_tlast and cause no output. The output stream carries LZW codes in
// m_tdata[11:0]; m_tlast marks the final code of each message.
// The first letter of a message only loads the prefix; when it is also the last letter,
// its own code is queued as the final code. Every other letter sends a search token down a
// row of DICT_SIZE-27 cells, one cell per cycle, and occupies the block until the token
// leaves the last cell and its codes are in the output buffer; the length of that cell row
// sets the rate. A letter yields zero, one or two codes, which are held in the pending
// result registers and pushed into the output buffer once it has room.
// The block takes one letter at a time: s_tready is high only when no search is in
// flight and the last results have been placed in a two-beat output buffer. While the
// receiver stalls, the buffer holds its codes and the next letter can still be
// accepted and searched; the block waits only when the buffer lacks room.
// After reset no message is in progress and the dictionary holds just the 26 single
// letters; the same happens after the final letter of every message. No clearing
// pass is needed, since an entry is searched only after it has been learned.
module lzw_letter_compressor #(
    parameter int DICT_SIZE = lzwlc_pkg::DICT_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lzwlc_pkg::IN_DATA_W-1:0]  s_tdata,   // [4:0] letter, [7:5] zero
    input  logic                             s_tlast,   // end of message
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lzwlc_pkg::OUT_DATA_W-1:0] m_tdata,   // [11:0] code, [15:12] zero
    output logic                             m_tlast    // last code of the message
);
    import lzwlc_pkg::*;

    localparam int NF_W   = $clog2(DICT_SIZE + 1);
    localparam int ADDR_W = $clog2(DICT_SIZE);

    state_t            state_reg;
    state_t            state_next;
    logic [CODE_W-1:0] prefix_reg;
    logic [CODE_W-1:0] prefix_next;
    logic              pv_reg;
    logic              pv_next;
    logic [NF_W-1:0]   nf_reg;
    logic [NF_W-1:0]   nf_next;
    logic [LET_W-1:0]  let_reg;
    logic [LET_W-1:0]  let_next;
    logic              eom_reg;
    logic              eom_next;
    tok_t              tok_in_reg;
    tok_t              tok_in_next;
    res_t              res0_reg;
    res_t              res0_next;
    res_t              res1_reg;
    res_t              res1_next;
    logic [1:0]        rn_reg;
    logic [1:0]        rn_next;

    tok_t              tok_out;
    logic              in_acc;
    logic              let_ok;
    logic [LET_W-1:0]  letter;
    logic [CODE_W-1:0] let_code;
    logic [CODE_W-1:0] held_code;
    logic [1:0]        dec_n;
    logic [1:0]        free;
    logic              push_ok;
    logic [1:0]        push_n;
    logic              wr_en;
    logic [CODE_W-1:0] new_prefix;

    assign letter    = s_tdata[LET_W-1:0];
    assign let_ok    = (letter < LET_W'(ALPHABET));
    assign in_acc    = s_tvalid && s_tready;
    assign let_code  = CODE_W'(letter) + CODE_W'(1);
    assign held_code = CODE_W'(let_reg) + CODE_W'(1);
    // A miss gives the old prefix; the end of a message adds the final code.
    assign dec_n     = {1'b0, !tok_out.found} + {1'b0, eom_reg};
    assign push_ok   = (rn_reg <= free);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && let_ok)
                begin
                    if (!pv_reg)
                    begin
                        state_next = s_tlast ? ST_PUSH : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tok_out.valid)
                begin
                    state_next = (dec_n != 2'd0) ? ST_PUSH : ST_IDLE;
                end
            end
            ST_PUSH:
            begin
                if (push_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and buffer controls.
    always_comb
    begin
        s_tready = 1'b0;
        push_n   = 2'd0;
        wr_en    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SEARCH:
            begin
                wr_en = tok_out.valid && !tok_out.found && (nf_reg < NF_W'(DICT_SIZE));
            end
            ST_PUSH:
            begin
                push_n = push_ok ? rn_reg : 2'd0;
            end
            default:
            begin
            end
        endcase
    end

    // Prefix, dictionary fill and pending results.
    always_comb
    begin
        prefix_next = prefix_reg;
        pv_next     = pv_reg;
        nf_next     = nf_reg;
        let_next    = let_reg;
        eom_next    = eom_reg;
        tok_in_next = '0;
        res0_next   = res0_reg;
        res1_next   = res1_reg;
        rn_next     = rn_reg;
        new_prefix  = prefix_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && let_ok)
                begin
                    if (!pv_reg)
                    begin
                        prefix_next = let_code;
                        pv_next     = 1'b1;
                        if (s_tlast)
                        begin
                            res0_next   = '{code: let_code, last: 1'b1};
                            rn_next     = 2'd1;
                            prefix_next = '0;
                            pv_next     = 1'b0;
                            nf_next     = NF_W'(FIRST_LEARNED);
                        end
                    end
                    else
                    begin
                        tok_in_next.valid = 1'b1;
                        tok_in_next.key   = {prefix_reg, letter};
                        let_next          = letter;
                        eom_next          = s_tlast;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tok_out.valid)
                begin
                    if (tok_out.found)
                    begin
                        new_prefix = tok_out.hit;
                        res0_next  = '{code: new_prefix, last: 1'b1};
                    end
                    else
                    begin
                        new_prefix = held_code;
                        res0_next  = '{code: prefix_reg, last: 1'b0};
                        res1_next  = '{code: new_prefix, last: 1'b1};
                        if (wr_en)
                        begin
                            nf_next = nf_reg + NF_W'(1);
                        end
                    end
                    rn_next = dec_n;
                    if (eom_reg)
                    begin
                        prefix_next = '0;
                        pv_next     = 1'b0;
                        nf_next     = NF_W'(FIRST_LEARNED);
                    end
                    else
                    begin
                        prefix_next = new_prefix;
                    end
                end
            end
            ST_PUSH:
            begin
                if (push_ok)
                begin
                    rn_next = 2'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        let_reg  <= let_next;
        eom_reg  <= eom_next;
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            prefix_reg <= '0;
            pv_reg     <= 1'b0;
            nf_reg     <= NF_W'(FIRST_LEARNED);
            tok_in_reg <= '0;
            rn_reg     <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
            pv_reg     <= pv_next;
            nf_reg     <= nf_next;
            tok_in_reg <= tok_in_next;
            rn_reg     <= rn_next;
        end
    end

    lzwlc_chain #(
        .DICT_SIZE (DICT_SIZE),
        .NF_W      (NF_W),
        .ADDR_W    (ADDR_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_in    (tok_in_reg),
        .tok_out   (tok_out),
        .wr_en     (wr_en),
        .wr_addr   (nf_reg[ADDR_W-1:0]),
        .wr_pair   ({prefix_reg, let_reg}),
        .next_free (nf_reg)
    );

    lzwlc_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_n   (push_n),
        .push_a   (res0_reg),
        .push_b   (res1_reg),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/lzwlc_cell.sv
// One dictionary cell: holds the pair of one learned code and passes the search token on.
// Depends on lzwlc_pkg.
module lzwlc_cell #(
    parameter int IDX    = 27,
    parameter int NF_W   = 13,
    parameter int ADDR_W = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lzwlc_pkg::tok_t           tok_in,
    output lzwlc_pkg::tok_t           tok_out,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [lzwlc_pkg::PAIR_W-1:0] wr_pair,
    input  logic [NF_W-1:0]           next_free
);
    import lzwlc_pkg::*;

    logic [PAIR_W-1:0] entry_reg;
    logic [PAIR_W-1:0] entry_next;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic              live;

    // The entry takes part in searches only once its code has been learned.
    assign live = (NF_W'(IDX) < next_free);

    always_comb
    begin
        entry_next = entry_reg;
        if (wr_en && (wr_addr == ADDR_W'(IDX)))
        begin
            entry_next = wr_pair;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found && live && (entry_reg == tok_in.key))
        begin
            tok_next.found = 1'b1;
            tok_next.hit   = CODE_W'(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/lzwlc_chain.sv
// Row of dictionary cells, one per learnable code; the token moves one cell per cycle.
// Depends on lzwlc_pkg and lzwlc_cell.
module lzwlc_chain #(
    parameter int DICT_SIZE = lzwlc_pkg::DICT_SIZE_DEF,
    parameter int NF_W      = $clog2(DICT_SIZE + 1),
    parameter int ADDR_W    = $clog2(DICT_SIZE)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lzwlc_pkg::tok_t              tok_in,
    output lzwlc_pkg::tok_t              tok_out,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [lzwlc_pkg::PAIR_W-1:0] wr_pair,
    input  logic [NF_W-1:0]              next_free
);
    import lzwlc_pkg::*;

    localparam int NCELL = DICT_SIZE - FIRST_LEARNED;

    tok_t link [NCELL+1];

    assign link[0] = tok_in;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        lzwlc_cell #(
            .IDX    (FIRST_LEARNED + g),
            .NF_W   (NF_W),
            .ADDR_W (ADDR_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (link[g]),
            .tok_out   (link[g+1]),
            .wr_en     (wr_en),
            .wr_addr   (wr_addr),
            .wr_pair   (wr_pair),
            .next_free (next_free)
        );
    end

    assign tok_out = link[NCELL];

endmodule

FILE: hw/rtl/lzwlc_out_buf.sv
// Two-entry result buffer that drives the output stream and takes up to two results at once.
// Depends on lzwlc_pkg.
module lzwlc_out_buf (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [1:0]                       push_n,
    input  lzwlc_pkg::res_t                  push_a,
    input  lzwlc_pkg::res_t                  push_b,
    output logic [1:0]                       free,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lzwlc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import lzwlc_pkg::*;

    res_t       q_reg [2];
    res_t       q_next [2];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign free     = 2'd2 - cnt_reg;

    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        cnt_next  = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            cnt_next  = cnt_reg - 2'd1;
        end
        case (push_n)
            2'd1:
            begin
                if (cnt_next == 2'd0)
                begin
                    q_next[0] = push_a;
                end
                else
                begin
                    q_next[1] = push_a;
                end
                cnt_next = cnt_next + 2'd1;
            end
            2'd2:
            begin
                q_next[0] = push_a;
                q_next[1] = push_b;
                cnt_next  = 2'd2;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign m_tdata = {(OUT_DATA_W - CODE_W)'(0), q_reg[0].code};
    assign m_tlast = q_reg[0].last;

endmodule
